### rtl/xbm_pkg.sv
// shared types and constants of the memory bank mapper
package xbm_pkg;

    localparam int BANK_SIZE_LOG2 = 14;
    localparam int ADDR_W         = 16;
    localparam int PORT_W         = 8;
    localparam int BANK_W         = 5;
    localparam int OFS_W          = 18;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 2;

    localparam logic [CFG_IDX_W-1:0]  CFG_MACHINE_KIND   = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_EXPANSION_MODE = 1'd1;

    localparam logic [CFG_DATA_W-1:0] MACH_EXT4   = 2'd1;
    localparam logic [CFG_DATA_W-1:0] MACH_EXT16  = 2'd2;
    localparam logic [CFG_DATA_W-1:0] XMODE_ALT   = 2'd1;
    localparam logic [CFG_DATA_W-1:0] XMODE_BLOCK = 2'd2;

    localparam logic [PORT_W-1:0] PORT_RESET = 8'hFF;
    localparam logic [BANK_W-1:0] BANK_MAX   = 5'd16;

    typedef enum logic [1:0] {
        OP_PORT_WR = 2'd0,
        OP_LCART   = 2'd1,
        OP_HCART   = 2'd2,
        OP_LOOKUP  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        RG_RAM      = 3'd0,
        RG_EXT_RAM  = 3'd1,
        RG_OS_ROM   = 3'd2,
        RG_BASIC    = 3'd3,
        RG_SELFTEST = 3'd4,
        RG_LCART    = 3'd5,
        RG_HCART    = 3'd6,
        RG_IO       = 3'd7
    } t_region;

    typedef struct packed {
        logic [PORT_W-1:0] port_latch;
        logic [BANK_W-1:0] bank;
        logic              selftest;
        logic              lcart;
        logic              hcart;
    } t_map_state;

endpackage

### rtl/xbm_in_if.sv
// input item channel of the memory bank mapper
interface xbm_in_if;
    import xbm_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          operation;
    logic [PORT_W-1:0]   port_value;
    logic                cart_on;
    logic [ADDR_W-1:0]   cpu_address;

    modport source (output valid, output operation, output port_value,
                    output cart_on, output cpu_address, input ready);
    modport sink   (input valid, input operation, input port_value,
                    input cart_on, input cpu_address, output ready);
endinterface

### rtl/xbm_out_if.sv
// result item channel of the memory bank mapper
interface xbm_out_if;
    import xbm_pkg::*;

    logic                valid;
    logic                ready;
    logic [2:0]          region;
    logic [OFS_W-1:0]    offset;
    logic [BANK_W-1:0]   bank_now;
    logic                os_rom_on;
    logic                basic_rom_on;
    logic                selftest_on;

    modport source (output valid, output region, output offset, output bank_now,
                    output os_rom_on, output basic_rom_on, output selftest_on,
                    input ready);
    modport sink   (input valid, input region, input offset, input bank_now,
                    input os_rom_on, input basic_rom_on, input selftest_on,
                    output ready);
endinterface

### rtl/xbm_lookup.sv
// cpu address to region and offset translation
module xbm_lookup
    import xbm_pkg::*;
(
    input  t_map_state         i_state,
    input  logic [ADDR_W-1:0]  i_addr,
    output t_region            o_region,
    output logic [OFS_W-1:0]   o_offset
);

    logic              w_basic_on;
    logic [BANK_W-1:0] w_bank_m1;

    assign w_basic_on = !i_state.port_latch[1] && !i_state.hcart;
    assign w_bank_m1  = i_state.bank - 5'd1;

    always_comb begin
        if (i_addr[15:11] == 5'b11010) begin
            o_region = RG_IO;
            o_offset = OFS_W'(i_addr[10:0]);
        end else if (i_state.port_latch[0] && i_addr[15:14] == 2'b11) begin
            o_region = RG_OS_ROM;
            o_offset = OFS_W'(i_addr[13:0]);
        end else if (i_addr[15:13] == 3'b101 && i_state.hcart) begin
            o_region = RG_HCART;
            o_offset = OFS_W'(i_addr[12:0]);
        end else if (i_addr[15:13] == 3'b101 && w_basic_on) begin
            o_region = RG_BASIC;
            o_offset = OFS_W'(i_addr[12:0]);
        end else if (i_addr[15:13] == 3'b100 && i_state.lcart) begin
            o_region = RG_LCART;
            o_offset = OFS_W'(i_addr[12:0]);
        end else if (i_addr[15:11] == 5'b01010 && i_state.selftest) begin
            o_region = RG_SELFTEST;
            o_offset = OFS_W'(i_addr[10:0]);
        end else if (i_addr[15:14] == 2'b01 && i_state.bank != '0) begin
            o_region = RG_EXT_RAM;
            o_offset = {w_bank_m1[OFS_W-BANK_SIZE_LOG2-1:0],
                        i_addr[BANK_SIZE_LOG2-1:0]};
        end else begin
            o_region = RG_RAM;
            o_offset = OFS_W'(i_addr);
        end
    end

endmodule

### rtl/xl_xe_memory_bank_mapper.sv
// top level of the memory bank mapper
// Each item is a bank port write, a cartridge window set or clear, or an
// address lookup, and yields exactly one result item carrying the region,
// the offset and the mapping state as it stands after the item. Items go
// through an input register and a result register with one pass of logic
// in between, so one item is taken every clock while the result side
// does not stall; a stalled item waits in the input register, and the input
// side is held only once both registers are full. Configuration writes take
// effect at once and are meant to be made while no item is in flight.
module xl_xe_memory_bank_mapper
    import xbm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    xbm_in_if.sink                i_in,
    xbm_out_if.source             o_out
);

    logic [CFG_DATA_W-1:0] r_machine;
    logic [CFG_DATA_W-1:0] r_expmode;

    logic                r_s1_valid;
    t_op                 r_s1_op;
    logic [PORT_W-1:0]   r_s1_pv;
    logic                r_s1_con;
    logic [ADDR_W-1:0]   r_s1_addr;

    t_map_state          r_state;
    t_map_state          n_state;

    logic                r_out_valid;
    t_region             r_out_region;
    logic [OFS_W-1:0]    r_out_offset;
    logic [BANK_W-1:0]   r_out_bank;
    logic                r_out_os;
    logic                r_out_basic;
    logic                r_out_st;

    logic                w_adv;
    logic [BANK_W-1:0]   w_dec_bank;
    logic                w_st;
    t_region             w_lk_region;
    logic [OFS_W-1:0]    w_lk_offset;
    t_region             n_region;
    logic [OFS_W-1:0]    n_offset;

    assign w_adv      = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_machine <= '0;
            r_expmode <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MACHINE_KIND:   r_machine <= i_cfg_wdata;
                CFG_EXPANSION_MODE: r_expmode <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_op   <= t_op'(i_in.operation);
            r_s1_pv   <= i_in.port_value;
            r_s1_con  <= i_in.cart_on;
            r_s1_addr <= i_in.cpu_address;
        end
    end

    // bank decode from the port byte
    always_comb begin
        if (r_s1_pv[4]) begin
            w_dec_bank = '0;
        end else if (r_machine == MACH_EXT16) begin
            if (r_expmode == XMODE_ALT) begin
                w_dec_bank = BANK_W'({r_s1_pv[6:5], r_s1_pv[3:2]}) + 5'd1;
            end else begin
                w_dec_bank = BANK_W'({r_s1_pv[7:6], r_s1_pv[3:2]}) + 5'd1;
            end
        end else begin
            w_dec_bank = BANK_W'(r_s1_pv[3:2]) + 5'd1;
        end
    end

    // next mapping state
    always_comb begin
        n_state = r_state;
        w_st    = r_state.selftest;
        unique case (r_s1_op)
            OP_PORT_WR: begin
                if ((r_machine == MACH_EXT4 || r_machine == MACH_EXT16)
                        && w_dec_bank != r_state.bank) begin
                    w_st         = 1'b0;
                    n_state.bank = w_dec_bank;
                end
                if (r_state.port_latch[0] && !r_s1_pv[0]) begin
                    w_st = 1'b0;
                end
                if (r_s1_pv[7]) begin
                    w_st = 1'b0;
                end else if (r_s1_pv[0] && (r_s1_pv[4] || r_expmode < XMODE_BLOCK)) begin
                    w_st = 1'b1;
                end
                n_state.selftest   = w_st;
                n_state.port_latch = r_s1_pv;
            end
            OP_LCART:  n_state.lcart = r_s1_con;
            OP_HCART:  n_state.hcart = r_s1_con;
            OP_LOOKUP: ;
            default: ;
        endcase
    end

    xbm_lookup u_lookup (
        .i_state  (r_state),
        .i_addr   (r_s1_addr),
        .o_region (w_lk_region),
        .o_offset (w_lk_offset)
    );

    always_comb begin
        if (r_s1_op == OP_LOOKUP) begin
            n_region = w_lk_region;
            n_offset = w_lk_offset;
        end else begin
            n_region = RG_RAM;
            n_offset = '0;
        end
    end

    // mapping state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.port_latch <= PORT_RESET;
            r_state.bank       <= '0;
            r_state.selftest   <= 1'b0;
            r_state.lcart      <= 1'b0;
            r_state.hcart      <= 1'b0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_region <= n_region;
            r_out_offset <= n_offset;
            r_out_bank   <= n_state.bank;
            r_out_os     <= n_state.port_latch[0];
            r_out_basic  <= !n_state.port_latch[1] && !n_state.hcart;
            r_out_st     <= n_state.selftest;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.region       = r_out_region;
    assign o_out.offset       = r_out_offset;
    assign o_out.bank_now     = r_out_bank;
    assign o_out.os_rom_on    = r_out_os;
    assign o_out.basic_rom_on = r_out_basic;
    assign o_out.selftest_on  = r_out_st;

    a_bank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bank <= BANK_MAX)
        else $error("bank out of range");

    a_ext_needs_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_region == RG_EXT_RAM |-> r_out_bank != '0)
        else $error("extended ram result without a bank");

    a_selftest_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_region == RG_SELFTEST |-> r_out_st)
        else $error("self-test region while flag is clear");

    a_hcart_basic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_region == RG_HCART |-> !r_out_basic)
        else $error("basic shown with high cartridge on");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_adv |=> r_s1_valid && $stable(r_state))
        else $error("stalled item lost or state moved");

endmodule
